// ----- design/wbps_pkg.sv -----
// wbps_pkg: shared constants and types for the wildcard byte pattern scanner
// no dependencies; used by wbps_cell and wildcard_byte_pattern_scan
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int ADDRESS_BITS = 48;
    localparam int COUNT_BITS = 32;
    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CARE_MASK = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_BASE = 3'd4;

    typedef struct packed {
        logic       active;
        logic       care;
        logic [7:0] pattern;
    } cell_ref_t;

endpackage

// ----- design/wbps_cell.sv -----
// wbps_cell: one window position, holds a byte, hands it on and compares it
// depends on wbps_pkg
module wbps_cell (
    input  logic               aclk,
    input  logic               shift_en,
    input  logic [7:0]         byte_in,
    input  wbps_pkg::cell_ref_t ref_i,
    output logic [7:0]         byte_out,
    output logic               miss_o
);
    import wbps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign miss_o = ref_i.active & ref_i.care & (byte_reg != ref_i.pattern);

endmodule

// ----- design/wildcard_byte_pattern_scan.sv -----
// wildcard_byte_pattern_scan: top level of the masked byte pattern scanner
// depends on wbps_pkg and wbps_cell
//
// Takes one byte per cycle into a row of window cells; the masked compare runs
// across all cells in the cycle after a byte is taken, alongside the add that
// forms the match address, so the block sustains one byte per cycle. It stalls
// only while a result is due and the output register still holds an untaken
// one. The first match of a region is reported once as base plus offset, and
// a region ending on tlast without a match reports not-found with address zero.
module wildcard_byte_pattern_scan (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // data_byte
    input  logic                                  s_tlast,   // region_end
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wbps_pkg::ADDRESS_BITS-1:0]     m_tdata,   // match_address
    output logic                                  m_tuser,   // found
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import wbps_pkg::*;

    logic [63:0]             pat_low_reg;
    logic [63:0]             pat_high_reg;
    logic [MAX_PATTERN-1:0]  care_reg;
    logic [4:0]              len_reg;
    logic [ADDRESS_BITS-1:0] base_reg;

    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    reported_reg, reported_next;
    logic                    pend_reg, pend_next;
    logic                    pend_last_reg, pend_last_next;
    logic                    m_tvalid_reg;
    logic                    m_tuser_reg;
    logic [ADDRESS_BITS-1:0] m_tdata_reg;

    logic [LEN_BITS-1:0]     len_eff;
    logic [127:0]            pat_vec;
    logic [7:0]              win [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]  miss;
    cell_ref_t               cref [MAX_PATTERN];

    logic                    hit, result_fire, stall, accept, flush_base;
    logic                    eff_rep, shift, drop_last;
    logic [COUNT_BITS-1:0]   base_count, offset;
    logic [ADDRESS_BITS-1:0] match_addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= '0;
            base_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                CFG_CARE_MASK:      care_reg     <= cfg_data[MAX_PATTERN-1:0];
                CFG_PATTERN_LENGTH: len_reg      <= cfg_data[4:0];
                CFG_REGION_BASE:    base_reg     <= cfg_data[ADDRESS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign len_eff = (len_reg > 5'(MAX_PATTERN)) ? LEN_BITS'(MAX_PATTERN)
                                                 : LEN_BITS'(len_reg);
    assign pat_vec = {pat_high_reg, pat_low_reg};

    // cell j compares against pattern byte len-1-j
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [IDX_BITS-1:0] idx;
        assign idx = IDX_BITS'(len_eff - LEN_BITS'(j) - LEN_BITS'(1));
        assign cref[j].active  = LEN_BITS'(j) < len_eff;
        assign cref[j].care    = care_reg[idx];
        assign cref[j].pattern = pat_vec[8*idx +: 8];

        wbps_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift),
            .byte_in  ((j == 0) ? s_tdata : win[(j == 0) ? 0 : j-1]),
            .ref_i    (cref[j]),
            .byte_out (win[j]),
            .miss_o   (miss[j])
        );
    end

    assign hit = (len_eff != '0) && (count_reg >= COUNT_BITS'(len_eff)) && !(|miss);
    assign result_fire = pend_reg & (hit | pend_last_reg);
    assign stall = result_fire & m_tvalid_reg & ~m_tready;
    assign s_tready = ~stall;
    assign accept = s_tvalid & s_tready;
    assign flush_base = pend_reg & pend_last_reg;
    assign eff_rep = flush_base ? 1'b0 : (reported_reg | (pend_reg & hit));
    assign shift = accept & ~eff_rep;
    assign drop_last = accept & eff_rep & s_tlast;
    assign base_count = flush_base ? '0 : count_reg;
    assign offset = count_reg - COUNT_BITS'(len_eff);
    assign match_addr = base_reg + ADDRESS_BITS'(offset);

    always_comb begin
        count_next     = count_reg;
        reported_next  = reported_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        if (!stall) begin
            pend_next      = shift;
            pend_last_next = s_tlast;
            if (shift) begin
                count_next    = (&base_count) ? base_count : base_count + 1'b1;
                reported_next = 1'b0;
            end else if (drop_last) begin
                count_next    = '0;
                reported_next = 1'b0;
            end else begin
                count_next    = base_count;
                reported_next = eff_rep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            if (result_fire && !stall) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (result_fire && !stall) begin
            m_tuser_reg <= hit;
            m_tdata_reg <= hit ? match_addr : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
